[sv/dtbsp_pkg.sv]
// Shared types and constants of the devicetree blob structure parser.
package dtbsp_pkg;

   localparam int NODE_LIMIT_DEFAULT = 128;
   localparam int PROPERTY_LIMIT = 256;

   localparam logic [31:0] MAGIC_WORD = 32'hD00DFEED;
   localparam logic [31:0] TOKEN_BEGIN_NODE = 32'd1;
   localparam logic [31:0] TOKEN_END_NODE = 32'd2;
   localparam logic [31:0] TOKEN_PROPERTY = 32'd3;
   localparam logic [31:0] TOKEN_NOP = 32'd4;
   localparam logic [31:0] TOKEN_END = 32'd9;

   localparam logic [2:0] EVENT_NODE_BEGIN = 3'd0;
   localparam logic [2:0] EVENT_PROPERTY = 3'd1;
   localparam logic [2:0] EVENT_NODE_END = 3'd2;
   localparam logic [2:0] EVENT_FINISHED = 3'd3;
   localparam logic [2:0] EVENT_ERROR = 3'd4;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
   localparam logic [1:0] STATUS_BAD_TOKEN = 2'd3;

   localparam int RSP_FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(RSP_FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(RSP_FIFO_DEPTH + 1);

   typedef struct packed {
      logic [31:0] blob_word;
      logic        final_word;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [1:0]  status_code;
      logic [6:0]  node_number;
      logic [7:0]  property_number;
      logic [7:0]  nest_depth;
      logic [32:0] name_offset;
      logic [31:0] value_offset;
      logic [31:0] value_length;
      logic        run_end;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } rsp_pair_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [6:0] node;
   } stack_cmd_type;

   function automatic rsp_type error_record(logic [1:0] status);
      rsp_type r;
      r = '0;
      r.event_kind = EVENT_ERROR;
      r.status_code = status;
      return r;
   endfunction

endpackage

[sv/dtbsp_stack.sv]
// Stack of open node numbers: top and next entry in registers, the rest in memory.
module dtbsp_stack import dtbsp_pkg::*; #(
   parameter int NODE_LIMIT = NODE_LIMIT_DEFAULT
) (
   input  logic          clock,
   input  stack_cmd_type cmd,
   input  logic [7:0]    depth,
   output logic [6:0]    top_node
);

   localparam int ADDR_W = (NODE_LIMIT > 1) ? $clog2(NODE_LIMIT) : 1;

   logic [6:0]        stack_mem [NODE_LIMIT];
   logic [6:0]        top_ff;
   logic [6:0]        below_ff;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   assign wr_addr = ADDR_W'(depth - 8'd1);
   assign rd_addr = ADDR_W'(depth - 8'd3);
   assign top_node = top_ff;

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         if (depth != 8'd0) begin
            stack_mem[wr_addr] <= top_ff;
         end
         below_ff <= top_ff;
         top_ff <= cmd.node;
      end else if (cmd.pop) begin
         top_ff <= below_ff;
         if (depth >= 8'd3) begin
            below_ff <= stack_mem[rd_addr];
         end
      end
   end

endmodule

[sv/dtbsp_parser.sv]
// Per-word header check and structure block walk, up to two records per word.
module dtbsp_parser import dtbsp_pkg::*; #(
   parameter int NODE_LIMIT = NODE_LIMIT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_type      item,
   output rsp_pair_type pair
);

   typedef enum logic [3:0] {
      PH_MAGIC, PH_HEADER, PH_SKIP, PH_ROOT, PH_NAME, PH_BODY,
      PH_CHILD, PH_PLEN, PH_PNAME, PH_VALUE, PH_TAIL, PH_DONE
   } phase_type;

   phase_type     phase_ff, phase_in, eff_phase;
   logic [29:0]   position_ff, position_in;
   logic [31:0]   total_size_ff, total_size_in;
   logic [29:0]   struct_word_ff, struct_word_in;
   logic [31:0]   strings_ff, strings_in;
   logic [7:0]    depth_ff, depth_in;
   logic [7:0]    nodes_ff, nodes_in;
   logic [8:0]    props_ff, props_in;
   logic [30:0]   words_left_ff, words_left_in;
   logic [31:0]   value_len_ff, value_len_in;

   logic [31:0]   word;
   logic [31:0]   byte_here;
   logic [32:0]   byte_next;
   logic [8:0]    props_m1;
   logic          past_end;
   logic          has_zero;
   logic          want_begin;
   logic          want_end;
   logic          word_hit;
   logic          final_hit;
   rsp_type       word_rec;
   rsp_type       final_rec;
   stack_cmd_type stack_cmd;
   stack_cmd_type stack_cmd_gated;
   logic [6:0]    top_node;

   assign word = item.blob_word;
   assign byte_here = {position_ff, 2'b00};
   assign byte_next = {1'b0, byte_here} + 33'd4;
   assign past_end = byte_next > {1'b0, total_size_ff};
   assign has_zero = (word[31:24] == 8'd0) || (word[23:16] == 8'd0) ||
                     (word[15:8] == 8'd0) || (word[7:0] == 8'd0);
   assign props_m1 = props_ff - 9'd1;
   assign final_rec = error_record(STATUS_TRUNCATED);

   always_comb begin
      phase_in = phase_ff;
      position_in = position_ff;
      total_size_in = total_size_ff;
      struct_word_in = struct_word_ff;
      strings_in = strings_ff;
      depth_in = depth_ff;
      nodes_in = nodes_ff;
      props_in = props_ff;
      words_left_in = words_left_ff;
      value_len_in = value_len_ff;
      word_rec = '0;
      word_hit = 1'b0;
      final_hit = 1'b0;
      want_begin = 1'b0;
      want_end = 1'b0;
      stack_cmd = '0;
      eff_phase = phase_ff;
      if (phase_ff == PH_SKIP && position_ff >= struct_word_ff) begin
         eff_phase = PH_ROOT;
      end

      if (phase_ff == PH_MAGIC) begin
         if (word != MAGIC_WORD) begin
            phase_in = PH_DONE;
            word_hit = 1'b1;
            word_rec = error_record(STATUS_BAD_MAGIC);
         end else begin
            phase_in = PH_HEADER;
         end
      end else if (phase_ff == PH_HEADER) begin
         if (position_ff == 30'd1) begin
            total_size_in = word;
         end else if (position_ff == 30'd2) begin
            struct_word_in = word[31:2];
         end else begin
            strings_in = word;
            phase_in = PH_SKIP;
         end
      end else if (phase_ff != PH_DONE && eff_phase != PH_SKIP) begin
         phase_in = eff_phase;
         if (past_end) begin
            phase_in = PH_DONE;
            word_hit = 1'b1;
            word_rec = error_record(STATUS_TRUNCATED);
         end else begin
            unique case (eff_phase)
               PH_ROOT: begin
                  if (word == TOKEN_BEGIN_NODE) begin
                     want_begin = 1'b1;
                  end else if (word != TOKEN_NOP) begin
                     phase_in = PH_DONE;
                     word_hit = 1'b1;
                     word_rec = error_record(STATUS_BAD_TOKEN);
                  end
               end
               PH_NAME: begin
                  if (has_zero) begin
                     phase_in = PH_BODY;
                  end
               end
               PH_BODY: begin
                  if (word == TOKEN_PROPERTY) begin
                     if (props_ff >= 9'(PROPERTY_LIMIT)) begin
                        phase_in = PH_DONE;
                        word_hit = 1'b1;
                        word_rec = error_record(STATUS_TRUNCATED);
                     end else begin
                        props_in = props_ff + 9'd1;
                        phase_in = PH_PLEN;
                     end
                  end else if (word == TOKEN_BEGIN_NODE) begin
                     want_begin = 1'b1;
                  end else if (word == TOKEN_END_NODE) begin
                     want_end = 1'b1;
                  end else if (word != TOKEN_NOP) begin
                     phase_in = PH_DONE;
                     word_hit = 1'b1;
                     word_rec = error_record(STATUS_BAD_TOKEN);
                  end
               end
               PH_CHILD: begin
                  if (word == TOKEN_BEGIN_NODE) begin
                     want_begin = 1'b1;
                  end else if (word == TOKEN_END_NODE) begin
                     want_end = 1'b1;
                  end else if (word != TOKEN_NOP) begin
                     phase_in = PH_DONE;
                     word_hit = 1'b1;
                     word_rec = error_record(STATUS_BAD_TOKEN);
                  end
               end
               PH_PLEN: begin
                  value_len_in = word;
                  phase_in = PH_PNAME;
               end
               PH_PNAME: begin
                  word_hit = 1'b1;
                  word_rec.event_kind = EVENT_PROPERTY;
                  word_rec.node_number = top_node;
                  word_rec.property_number = props_m1[7:0];
                  word_rec.nest_depth = depth_ff - 8'd1;
                  word_rec.name_offset = {1'b0, strings_ff} + {1'b0, word};
                  word_rec.value_offset = byte_next[31:0];
                  word_rec.value_length = value_len_ff;
                  words_left_in = {1'b0, value_len_ff[31:2]} +
                                  31'(value_len_ff[1:0] != 2'd0);
                  phase_in = (words_left_in != 31'd0) ? PH_VALUE : PH_BODY;
               end
               PH_VALUE: begin
                  words_left_in = words_left_ff - 31'd1;
                  if (words_left_ff == 31'd1) begin
                     phase_in = PH_BODY;
                  end
               end
               default: begin
                  if (word == TOKEN_END) begin
                     phase_in = PH_DONE;
                     word_hit = 1'b1;
                     word_rec.event_kind = EVENT_FINISHED;
                  end else if (word != TOKEN_NOP) begin
                     phase_in = PH_DONE;
                     word_hit = 1'b1;
                     word_rec = error_record(STATUS_BAD_TOKEN);
                  end
               end
            endcase

            if (want_begin) begin
               if (nodes_ff >= 8'(NODE_LIMIT)) begin
                  phase_in = PH_DONE;
                  word_hit = 1'b1;
                  word_rec = error_record(STATUS_TRUNCATED);
               end else begin
                  word_hit = 1'b1;
                  word_rec.event_kind = EVENT_NODE_BEGIN;
                  word_rec.node_number = nodes_ff[6:0];
                  word_rec.nest_depth = depth_ff;
                  word_rec.name_offset = byte_next;
                  stack_cmd.push = 1'b1;
                  stack_cmd.node = nodes_ff[6:0];
                  nodes_in = nodes_ff + 8'd1;
                  depth_in = depth_ff + 8'd1;
                  phase_in = PH_NAME;
               end
            end
            if (want_end) begin
               depth_in = depth_ff - 8'd1;
               word_hit = 1'b1;
               word_rec.event_kind = EVENT_NODE_END;
               word_rec.node_number = top_node;
               word_rec.nest_depth = depth_in;
               stack_cmd.pop = 1'b1;
               phase_in = (depth_in == 8'd0) ? PH_TAIL : PH_CHILD;
            end
         end
      end

      if (phase_in != PH_DONE) begin
         position_in = position_ff + 30'd1;
      end

      if (item.final_word) begin
         final_hit = (phase_in != PH_DONE);
         phase_in = PH_MAGIC;
         position_in = '0;
         total_size_in = '0;
         struct_word_in = '0;
         strings_in = '0;
         depth_in = '0;
         nodes_in = '0;
         props_in = '0;
         words_left_in = '0;
         value_len_in = '0;
      end
   end

   always_comb begin
      pair.count = fire ? (2'(word_hit) + 2'(final_hit)) : 2'd0;
      pair.first = word_hit ? word_rec : final_rec;
      pair.first.run_end = !(word_hit && final_hit);
      pair.second = final_rec;
      pair.second.run_end = 1'b1;
      stack_cmd_gated = stack_cmd;
      stack_cmd_gated.push = stack_cmd.push && fire;
      stack_cmd_gated.pop = stack_cmd.pop && fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC;
         position_ff <= '0;
         total_size_ff <= '0;
         struct_word_ff <= '0;
         strings_ff <= '0;
         depth_ff <= '0;
         nodes_ff <= '0;
         props_ff <= '0;
         words_left_ff <= '0;
         value_len_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         position_ff <= position_in;
         total_size_ff <= total_size_in;
         struct_word_ff <= struct_word_in;
         strings_ff <= strings_in;
         depth_ff <= depth_in;
         nodes_ff <= nodes_in;
         props_ff <= props_in;
         words_left_ff <= words_left_in;
         value_len_ff <= value_len_in;
      end
   end

   dtbsp_stack #(
      .NODE_LIMIT (NODE_LIMIT)
   ) u_stack (
      .clock    (clock),
      .cmd      (stack_cmd_gated),
      .depth    (depth_ff),
      .top_node (top_node)
   );

`ifndef SYNTH
   a_depth_le_nodes: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= nodes_ff)
      else $error("open node depth exceeds nodes begun");
   a_nodes_le_limit: assert property (@(posedge clock) disable iff (reset)
      nodes_ff <= 8'(NODE_LIMIT))
      else $error("node count past limit");
   a_props_le_limit: assert property (@(posedge clock) disable iff (reset)
      props_ff <= 9'(PROPERTY_LIMIT))
      else $error("property count past limit");
`endif

endmodule

[sv/dtbsp_fifo.sv]
// Result queue taking up to two records per cycle and handing out one while rsp_ready is high.
module dtbsp_fifo import dtbsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rsp_pair_type pair,
   output logic         room,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   rsp_type               entries_ff [RSP_FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  pop;

   assign rsp_valid = count_ff != '0;
   assign rsp_data = entries_ff[rd_ptr_ff];
   assign pop = rsp_valid && rsp_ready;
   assign room = count_ff <= FIFO_CNT_W'(RSP_FIFO_DEPTH - 2);
   assign wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(pair.count);
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
   assign count_in = count_ff + FIFO_CNT_W'(pair.count) - FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pair.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= pair.first;
      end
      if (pair.count == 2'd2) begin
         entries_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= pair.second;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(RSP_FIFO_DEPTH))
      else $error("result queue count past depth");
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      pair.count != 2'd0 |-> room)
      else $error("result queue written without room");
`endif

endmodule

[sv/devicetree_blob_structure_parser.sv]
// Top level: input register, parser with node stack, result queue.
// A word's records pass from the input register through the parser into the result queue before rsp.
// Throughput: one blob word per cycle while the result queue has room.
// The queue takes a word's records only with room for two, so req_ready follows queue room while a word is held.
// Reset: synchronous, clears parser phase, counters and queue; no clearing pass.
// A final word rearms the parser for the next blob on the following cycle.
module devicetree_blob_structure_parser import dtbsp_pkg::*; #(
   parameter int NODE_LIMIT = NODE_LIMIT_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic         item_valid_ff;
   req_type      item_ff;
   logic         room;
   logic         fire;
   rsp_pair_type pair;

   assign fire = item_valid_ff && room;
   assign req_ready = !item_valid_ff || room;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   dtbsp_parser #(
      .NODE_LIMIT (NODE_LIMIT)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (item_ff),
      .pair  (pair)
   );

   dtbsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .pair      (pair),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[verif/tb_top.sv]
// Testbench for the devicetree blob structure parser: directed and random blobs, scoreboard, stall checks.
`timescale 1ns / 100ps

module tb_top;
   import dtbsp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned TOTAL_WORDS = 550;

   typedef enum logic [3:0] {
      SCAN_MAGIC, SCAN_HEADER, SCAN_SKIP, SCAN_ROOT, SCAN_NAME, SCAN_BODY,
      SCAN_CHILD, SCAN_PLEN, SCAN_PNAME, SCAN_VALUE, SCAN_TAIL, SCAN_DONE
   } scan_phase_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    rsp_hold = 1'b0;

   req_type     pending_words[$];
   rsp_type     expected_records[$];
   rsp_type     step_records[$];
   logic [31:0] blob[$];
   bit          blob_cut;
   int unsigned words_queued = 0;
   int unsigned fail_count = 0;
   int unsigned req_gap = 0;
   int unsigned req_calm = 0;
   int unsigned rsp_stall = 0;
   int unsigned rsp_calm = 0;
   int unsigned hold_cycles = 0;
   int unsigned cycle_count = 0;

   scan_phase_type scan;
   logic [29:0] word_pos;
   logic [31:0] blob_size;
   logic [29:0] struct_word;
   logic [31:0] strings_base;
   logic [7:0]  open_depth;
   logic [7:0]  nodes_seen;
   logic [8:0]  props_seen;
   logic [31:0] value_left;
   logic [31:0] held_len;
   logic [7:0]  node_stack[256];

   devicetree_blob_structure_parser dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void rearm_parser();
      scan = SCAN_MAGIC;
      word_pos = '0;
      blob_size = '0;
      struct_word = '0;
      strings_base = '0;
      open_depth = '0;
      nodes_seen = '0;
      props_seen = '0;
      value_left = '0;
      held_len = '0;
      foreach (node_stack[i]) node_stack[i] = '0;
   endfunction

   function automatic void add_rec(logic [2:0] kind, logic [1:0] status, logic [6:0] node,
                                   logic [7:0] prop, logic [7:0] depth, logic [32:0] name,
                                   logic [31:0] voff, logic [31:0] vlen);
      rsp_type r;
      r = '0;
      r.event_kind = kind;
      r.status_code = status;
      r.node_number = node;
      r.property_number = prop;
      r.nest_depth = depth;
      r.name_offset = name;
      r.value_offset = voff;
      r.value_length = vlen;
      step_records.push_back(r);
   endfunction

   function automatic void parse_fail(logic [1:0] status);
      scan = SCAN_DONE;
      add_rec(EVENT_ERROR, status, '0, '0, '0, '0, '0, '0);
   endfunction

   function automatic void open_node(logic [32:0] byte_here);
      logic [7:0] idx;
      if (nodes_seen >= NODE_LIMIT_DEFAULT) begin
         parse_fail(STATUS_TRUNCATED);
      end else begin
         idx = nodes_seen;
         nodes_seen = nodes_seen + 8'd1;
         node_stack[open_depth] = idx;
         add_rec(EVENT_NODE_BEGIN, STATUS_OK, idx[6:0], '0, open_depth, byte_here + 33'd4,
                 '0, '0);
         open_depth = open_depth + 8'd1;
         scan = SCAN_NAME;
      end
   endfunction

   function automatic void close_node();
      open_depth = open_depth - 8'd1;
      add_rec(EVENT_NODE_END, STATUS_OK, node_stack[open_depth][6:0], '0, open_depth,
              '0, '0, '0);
      scan = (open_depth == 8'd0) ? SCAN_TAIL : SCAN_CHILD;
   endfunction

   function automatic void parse_word_records(req_type item);
      logic [31:0] w;
      logic [32:0] byte_here;
      logic [32:0] after_word;
      logic [7:0]  d;
      w = item.blob_word;
      step_records.delete();
      if (scan == SCAN_MAGIC) begin
         if (w != MAGIC_WORD) parse_fail(STATUS_BAD_MAGIC);
         else scan = SCAN_HEADER;
      end else if (scan == SCAN_HEADER) begin
         if (word_pos == 30'd1) begin
            blob_size = w;
         end else if (word_pos == 30'd2) begin
            struct_word = w[31:2];
         end else begin
            strings_base = w;
            scan = SCAN_SKIP;
         end
      end else if (scan != SCAN_DONE) begin
         if (scan == SCAN_SKIP && word_pos >= struct_word) scan = SCAN_ROOT;
         if (scan != SCAN_SKIP) begin
            byte_here = {1'b0, word_pos, 2'b00};
            after_word = byte_here + 33'd4;
            if (after_word > {1'b0, blob_size}) begin
               parse_fail(STATUS_TRUNCATED);
            end else begin
               case (scan)
                  SCAN_ROOT: begin
                     if (w == TOKEN_BEGIN_NODE) open_node(byte_here);
                     else if (w != TOKEN_NOP) parse_fail(STATUS_BAD_TOKEN);
                  end
                  SCAN_NAME: begin
                     if (w[31:24] == 8'd0 || w[23:16] == 8'd0 || w[15:8] == 8'd0 ||
                         w[7:0] == 8'd0) scan = SCAN_BODY;
                  end
                  SCAN_BODY: begin
                     if (w == TOKEN_PROPERTY) begin
                        if (props_seen >= PROPERTY_LIMIT) begin
                           parse_fail(STATUS_TRUNCATED);
                        end else begin
                           props_seen = props_seen + 9'd1;
                           scan = SCAN_PLEN;
                        end
                     end else if (w == TOKEN_BEGIN_NODE) begin
                        open_node(byte_here);
                     end else if (w == TOKEN_END_NODE) begin
                        close_node();
                     end else if (w != TOKEN_NOP) begin
                        parse_fail(STATUS_BAD_TOKEN);
                     end
                  end
                  SCAN_CHILD: begin
                     if (w == TOKEN_BEGIN_NODE) open_node(byte_here);
                     else if (w == TOKEN_END_NODE) close_node();
                     else if (w != TOKEN_NOP) parse_fail(STATUS_BAD_TOKEN);
                  end
                  SCAN_PLEN: begin
                     held_len = w;
                     scan = SCAN_PNAME;
                  end
                  SCAN_PNAME: begin
                     d = open_depth - 8'd1;
                     add_rec(EVENT_PROPERTY, STATUS_OK, node_stack[d][6:0],
                             8'(props_seen - 9'd1), d,
                             {1'b0, strings_base} + {1'b0, w}, after_word[31:0], held_len);
                     value_left = (held_len >> 2) + {31'd0, held_len[1:0] != 2'b00};
                     scan = (value_left != 32'd0) ? SCAN_VALUE : SCAN_BODY;
                  end
                  SCAN_VALUE: begin
                     value_left = value_left - 32'd1;
                     if (value_left == 32'd0) scan = SCAN_BODY;
                  end
                  default: begin
                     if (w == TOKEN_END) begin
                        scan = SCAN_DONE;
                        add_rec(EVENT_FINISHED, STATUS_OK, '0, '0, '0, '0, '0, '0);
                     end else if (w != TOKEN_NOP) begin
                        parse_fail(STATUS_BAD_TOKEN);
                     end
                  end
               endcase
            end
         end
      end
      if (scan != SCAN_DONE) word_pos = word_pos + 30'd1;
      if (item.final_word) begin
         if (scan != SCAN_DONE) add_rec(EVENT_ERROR, STATUS_TRUNCATED, '0, '0, '0, '0, '0, '0);
         rearm_parser();
      end
      if (step_records.size() > 0) step_records[step_records.size() - 1].run_end = 1'b1;
      foreach (step_records[i]) expected_records.push_back(step_records[i]);
   endfunction

   function automatic int unsigned pick_gap(inout int unsigned calm);
      int unsigned r;
      if (calm > 0) begin
         calm = calm - 1;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) calm = $urandom_range(20, 60);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   function automatic void report_record(string what, rsp_type want, rsp_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s at %0t", what, $realtime);
         $display("  want k %0d s %0d n %0d p %0d d %0d name %h voff %h vlen %h e %0b",
                  want.event_kind, want.status_code, want.node_number, want.property_number,
                  want.nest_depth, want.name_offset, want.value_offset, want.value_length,
                  want.run_end);
         $display("  got  k %0d s %0d n %0d p %0d d %0d name %h voff %h vlen %h e %0b",
                  got.event_kind, got.status_code, got.node_number, got.property_number,
                  got.nest_depth, got.name_offset, got.value_offset, got.value_length,
                  got.run_end);
      end
   endfunction

   function automatic void queue_blob();
      req_type item;
      foreach (blob[i]) begin
         item.blob_word = blob[i];
         item.final_word = (i == blob.size() - 1);
         pending_words.push_back(item);
      end
      words_queued += blob.size();
   endfunction

   function automatic void maybe_nop();
      if ($urandom_range(0, 5) == 0) blob.push_back(TOKEN_NOP);
   endfunction

   function automatic void add_property();
      logic [31:0] len;
      int unsigned words;
      if (blob_cut) return;
      blob.push_back(TOKEN_PROPERTY);
      if ($urandom_range(0, 29) == 0) begin
         len = $urandom_range(0, 1) ? 32'hFFFF_FFFC + $urandom_range(0, 3) : $urandom;
         blob_cut = 1'b1;
         words = $urandom_range(0, 2);
      end else begin
         len = $urandom_range(0, 12);
         words = (len + 3) / 4;
      end
      blob.push_back(len);
      blob.push_back($urandom);
      repeat (words) blob.push_back($urandom);
   endfunction

   function automatic void add_node(int unsigned level);
      logic [31:0] w;
      int unsigned zero_byte;
      if (blob_cut) return;
      maybe_nop();
      blob.push_back(TOKEN_BEGIN_NODE);
      repeat ($urandom_range(0, 2)) blob.push_back($urandom | 32'h0101_0101);
      w = $urandom;
      zero_byte = $urandom_range(0, 3);
      w[8 * zero_byte +: 8] = 8'h00;
      blob.push_back(w);
      repeat ($urandom_range(0, 3)) add_property();
      if (level < 3) repeat ($urandom_range(0, (level == 0) ? 3 : 2)) add_node(level + 1);
      // a property after the children breaks the grammar when children exist
      if ($urandom_range(0, 19) == 0) add_property();
      maybe_nop();
      if (!blob_cut) blob.push_back(TOKEN_END_NODE);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) parse_word_records(req_data);
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_data <= pending_words.pop_front();
               req_valid <= 1'b1;
               req_gap = pick_gap(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_records.size() == 0) begin
               report_record("unexpected record", '0, rsp_data);
            end else begin
               want = expected_records.pop_front();
               if (rsp_data.event_kind !== want.event_kind ||
                   rsp_data.status_code !== want.status_code ||
                   rsp_data.node_number !== want.node_number ||
                   rsp_data.property_number !== want.property_number ||
                   rsp_data.nest_depth !== want.nest_depth ||
                   rsp_data.name_offset !== want.name_offset ||
                   rsp_data.value_offset !== want.value_offset ||
                   rsp_data.value_length !== want.value_length ||
                   rsp_data.run_end !== want.run_end)
                  report_record("record mismatch", want, rsp_data);
            end
            rsp_stall = pick_gap(rsp_calm);
         end
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall = rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // long receiver hold-off so the result queue fills and backs up the input
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles = 0;
         rsp_hold <= 1'b0;
      end else begin
         hold_cycles++;
         rsp_hold <= (hold_cycles >= 400 && hold_cycles < 700);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned skip, cut_at, pos, r;
      rearm_parser();

      blob = '{32'h0000_0000};
      queue_blob();
      blob = '{MAGIC_WORD, 32'hFFFF_FFFF, 32'h0000_0003, 32'hFFFF_FFFF, TOKEN_NOP,
               TOKEN_BEGIN_NODE, 32'hFFFF_FF00, TOKEN_PROPERTY, 32'd5, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'h0000_0000, TOKEN_BEGIN_NODE, 32'h6100_0000,
               TOKEN_END_NODE, TOKEN_END_NODE, TOKEN_END, 32'hFFFF_FFFF};
      queue_blob();
      blob = '{MAGIC_WORD, 32'd64, 32'd16, 32'd0, TOKEN_BEGIN_NODE};
      queue_blob();

      // overflow the node table with a deep chain
      blob = '{MAGIC_WORD, 32'hFFFF_FFFF, 32'd16, $urandom};
      repeat (NODE_LIMIT_DEFAULT + 1) begin
         blob.push_back(TOKEN_BEGIN_NODE);
         blob.push_back(32'h7800_0000);
      end
      blob.push_back(TOKEN_END_NODE);
      queue_blob();

      while (words_queued < TOTAL_WORDS) begin
         blob.delete();
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 5)) blob.push_back($urandom);
            if ($urandom_range(0, 1)) blob[0] = MAGIC_WORD;
         end else begin
            blob_cut = 1'b0;
            skip = $urandom_range(0, 3);
            blob.push_back(MAGIC_WORD);
            blob.push_back(32'd0);
            if (skip == 0 && $urandom_range(0, 3) == 0) blob.push_back($urandom_range(0, 15));
            else blob.push_back((4 + skip) * 4 + $urandom_range(0, 3));
            blob.push_back($urandom);
            repeat (skip) blob.push_back($urandom);
            maybe_nop();
            add_node(0);
            maybe_nop();
            if (!blob_cut) blob.push_back(TOKEN_END);
            r = $urandom_range(0, 9);
            if (r == 0) blob[1] = $urandom_range(16, blob.size() * 4);
            else if (r == 1) blob[1] = $urandom;
            else blob[1] = blob.size() * 4 + $urandom_range(0, 1) * $urandom_range(0, 64);
            repeat ($urandom_range(0, 2)) blob.push_back($urandom);
            if ($urandom_range(0, 7) == 0) begin
               pos = $urandom_range(4, blob.size() - 1);
               blob[pos] = $urandom_range(0, 1) ? $urandom_range(0, 10) : $urandom;
            end
            if ($urandom_range(0, 9) == 0) begin
               cut_at = $urandom_range(1, blob.size());
               while (blob.size() > cut_at) void'(blob.pop_back());
            end
         end
         queue_blob();
      end

      while (pending_words.size() != 0 || req_valid) @(posedge clock);
      while (expected_records.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_records.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

endmodule
